### rtl/ajb_pkg.sv
// ----------------------------------------------------------------------------
// ajb_pkg
// Types and constants shared by the jitter buffer controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ajb_pkg;

	localparam int unsigned LEVEL_W = 12;
	localparam int unsigned DISC_W  = 16;
	localparam int unsigned GAIN_W  = 17;
	localparam int unsigned BLOCK_W = 7;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

	localparam logic [LEVEL_W-1:0] PRIME_RST  = 12'd480;
	localparam logic [LEVEL_W-1:0] TARGET_RST = 12'd720;
	localparam logic [LEVEL_W-1:0] MAX_RST    = 12'd1440;
	localparam logic [LEVEL_W-1:0] RAMP_RST   = 12'd96;

	localparam logic [CFG_IDX_W-1:0] REG_PRIME  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 8'd3;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_PROD  = 2'd2,
		ACT_CONS  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EK_ONE  = 2'd0,
		EK_SIL  = 2'd1,
		EK_PROD = 2'd2
	} emit_kind_t;

	typedef struct packed {
		logic       latch;
		logic       decide;
		logic       plan;
		logic       div_step;
		logic       pop_rd;
		logic       mul;
		logic       mul_pop;
		logic       tail_g;
		logic       emit;
		emit_kind_t emit_kind;
	} ajb_cmd_t;

	typedef struct packed {
		action_t action;
		logic    zero_block;
		logic    plan_silent;
		logic    copied_nz;
		logic    div_done;
		logic    pops_left;
		logic    is_last;
		logic    out_free;
	} ajb_status_t;

endpackage

`default_nettype wire

### rtl/audio_jitter_buffer_fade.sv
// ----------------------------------------------------------------------------
// audio_jitter_buffer_fade
// Stereo audio jitter buffer with priming, stale-audio trimming and fades.
//
//   Channel   Direction  Handshake                Contents
//   s_axis    in         s_tvalid / s_tready      command word, kind in s_tuser
//   m_axis    out        m_tvalid / m_tready      result word, tlast, from-queue
//   cfg       in         cfg_valid / cfg_ready    register index and value
//
// A write or activity word is latched, decoded and emitted. A read is decoded,
// planned and run through the gain divider, then each frame popped from the
// queue passes the frame store's registered read and the multiplier stage.
// Silent reads give one frame per cycle after planning while the output is not
// stalled. Reset clears all control state; the frame store is not cleared. A
// stalled output holds the sequencer until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_jitter_buffer_fade #(
	parameter int unsigned QUEUE_FRAMES = 4096,
	parameter int unsigned MAX_BLOCK    = 64,
	parameter int unsigned SAMPLE_BITS  = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// sample_left, sample_right, block_frames, active_flag
	input  wire logic [((2*SAMPLE_BITS+8+7)/8)*8-1:0] s_tdata,
	// action
	input  wire logic [1:0] s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// out_left, out_right, write_accepted, primed_now, fill_level,
	// discontinuity_count
	output logic [((2*SAMPLE_BITS+30+7)/8)*8-1:0] m_tdata,
	// from_queue
	output logic [0:0] m_tuser,
	output logic      m_tlast,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ajb_pkg::LEVEL_W-1:0]   cfg_data
);

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned OW = ((2*SB+30+7)/8)*8;

	ajb_pkg::ajb_cmd_t    cmd;
	ajb_pkg::ajb_status_t st;
	logic [SB-1:0] o_left, o_right;
	logic          o_acc, o_primed;
	logic [ajb_pkg::LEVEL_W-1:0] o_fill;
	logic [ajb_pkg::DISC_W-1:0]  o_disc;

	assign cfg_ready = 1'b1;

	ajb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	ajb_dp #(
		.QUEUE_FRAMES(QUEUE_FRAMES),
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_valid),
		.cfg_idx       (cfg_index),
		.cfg_val       (cfg_data),
		.in_action     (s_tuser),
		.in_left       (s_tdata[SB-1:0]),
		.in_right      (s_tdata[2*SB-1:SB]),
		.in_block      (s_tdata[2*SB+6:2*SB]),
		.in_flag       (s_tdata[2*SB+7]),
		.cmd           (cmd),
		.st            (st),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_left      (o_left),
		.out_right     (o_right),
		.out_from_queue(m_tuser[0]),
		.out_last      (m_tlast),
		.out_accepted  (o_acc),
		.out_primed    (o_primed),
		.out_fill      (o_fill),
		.out_disc      (o_disc)
	);

	assign m_tdata = OW'({o_disc, o_fill, o_primed, o_acc, o_right, o_left});

endmodule

`default_nettype wire

### rtl/ajb_ram.sv
// ----------------------------------------------------------------------------
// ajb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/ajb_ctrl.sv
// ----------------------------------------------------------------------------
// ajb_ctrl
// Sequencer for one item at a time: decode, plan, divide, pop, fade, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ajb_pkg::ajb_status_t st,
	output ajb_pkg::ajb_cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_ONE, S_PLAN, S_DIV, S_POP_RD, S_POP_MUL,
		S_TAIL_G, S_TAIL_MUL, S_EMIT, S_SIL
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.emit_kind = ajb_pkg::EK_ONE;
		case (state_q)
			S_IDLE: cmd.latch = in_valid;
			S_DECIDE: cmd.decide = 1'b1;
			S_ONE: begin
				cmd.emit = st.out_free;
				cmd.emit_kind = ajb_pkg::EK_ONE;
			end
			S_PLAN: cmd.plan = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_POP_RD: cmd.pop_rd = 1'b1;
			S_POP_MUL: begin
				cmd.mul = 1'b1;
				cmd.mul_pop = 1'b1;
			end
			S_TAIL_G: cmd.tail_g = 1'b1;
			S_TAIL_MUL: cmd.mul = 1'b1;
			S_EMIT: begin
				cmd.emit = st.out_free;
				cmd.emit_kind = ajb_pkg::EK_PROD;
			end
			S_SIL: begin
				cmd.emit = st.out_free;
				cmd.emit_kind = ajb_pkg::EK_SIL;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (st.action == ajb_pkg::ACT_READ) begin
						state_q <= st.zero_block ? S_IDLE : S_PLAN;
					end else begin
						state_q <= S_ONE;
					end
				end
				S_ONE: if (st.out_free) state_q <= S_IDLE;
				S_PLAN: state_q <= st.plan_silent ? S_SIL : S_DIV;
				S_DIV: begin
					if (st.div_done) begin
						state_q <= st.copied_nz ? S_POP_RD : S_TAIL_G;
					end
				end
				S_POP_RD: state_q <= S_POP_MUL;
				S_POP_MUL: state_q <= S_EMIT;
				S_TAIL_G: state_q <= S_TAIL_MUL;
				S_TAIL_MUL: state_q <= S_EMIT;
				S_EMIT: begin
					if (st.out_free) begin
						if (st.is_last) state_q <= S_IDLE;
						else if (st.pops_left) state_q <= S_POP_RD;
						else state_q <= S_TAIL_G;
					end
				end
				S_SIL: if (st.out_free && st.is_last) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/ajb_dp.sv
// ----------------------------------------------------------------------------
// ajb_dp
// Datapath: queue pointers, frame store, gain envelope, divider, multipliers
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_dp #(
	parameter int unsigned QUEUE_FRAMES = 4096,
	parameter int unsigned MAX_BLOCK    = 64,
	parameter int unsigned SAMPLE_BITS  = 24
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr,
	input  wire logic [ajb_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [ajb_pkg::LEVEL_W-1:0]        cfg_val,
	input  wire logic [1:0]                         in_action,
	input  wire logic [SAMPLE_BITS-1:0]             in_left,
	input  wire logic [SAMPLE_BITS-1:0]             in_right,
	input  wire logic [ajb_pkg::BLOCK_W-1:0]        in_block,
	input  wire logic                               in_flag,
	input  wire ajb_pkg::ajb_cmd_t                  cmd,
	output ajb_pkg::ajb_status_t                    st,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output logic [SAMPLE_BITS-1:0]                  out_left,
	output logic [SAMPLE_BITS-1:0]                  out_right,
	output logic                                    out_from_queue,
	output logic                                    out_last,
	output logic                                    out_accepted,
	output logic                                    out_primed,
	output logic [ajb_pkg::LEVEL_W-1:0]             out_fill,
	output logic [ajb_pkg::DISC_W-1:0]              out_disc
);

	localparam int unsigned AW = $clog2(QUEUE_FRAMES);
	localparam int unsigned PW = AW + 1;
	localparam int unsigned CW = ((AW > ajb_pkg::LEVEL_W) ? AW : ajb_pkg::LEVEL_W) + 1;
	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned MW = SB + 18;
	localparam int unsigned BW = ajb_pkg::BLOCK_W;
	localparam int unsigned LW = ajb_pkg::LEVEL_W;
	localparam int unsigned GW = ajb_pkg::GAIN_W;
	localparam logic [PW-1:0] DEPTH_P = PW'(QUEUE_FRAMES);
	localparam logic [AW-1:0] FULL_FILL = AW'(QUEUE_FRAMES - 1);
	localparam logic [BW-1:0] MAX_BLK = BW'(MAX_BLOCK);

	// Configuration.
	logic [LW-1:0] prime_q, target_q, max_q, ramp_q;

	// Item registers.
	ajb_pkg::action_t action_q;
	logic [SB-1:0] left_q, right_q;
	logic [BW-1:0] block_q;
	logic          flag_q;

	// Queue and envelope state.
	logic [AW-1:0] rd_ptr_q, wr_ptr_q;
	logic          primed_q, prod_on_q, cons_on_q;
	logic [GW-1:0] gain_q;
	logic [SB-1:0] held_l_q, held_r_q;
	logic [ajb_pkg::DISC_W-1:0] disc_q;
	logic          acc_q;

	// Read plan.
	logic [BW-1:0] frames_q, copied_q, pop_cnt_q, frame_idx_q, tail_cnt_q;
	logic          underflow_q;
	logic [LW-1:0] fill_rep_q;

	// Divider and fade-out accumulator.
	logic [4:0]    div_cnt_q;
	logic [LW:0]   div_rem_q;
	logic [GW-1:0] div_quo_q;
	logic [23:0]   tq_q;
	logic [LW:0]   tr_q;
	logic [GW-1:0] tg_q;

	logic [MW-1:0] prod_l_q, prod_r_q;

	// Frame store.
	logic [2*SB-1:0] ram_rdata;
	logic            ram_we;

	ajb_ram #(
		.WIDTH(2 * SB),
		.DEPTH(QUEUE_FRAMES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr_q),
		.wdata({right_q, left_q}),
		.re   (cmd.pop_rd),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// Fill and comparisons.
	logic [PW-1:0] fill_p;
	logic [AW-1:0] fill;
	logic [CW-1:0] fill_c, prime_c, target_c, max_c, frames_c;
	logic          write_ok, trim, plan_silent;
	logic [AW-1:0] trim_n;
	logic [PW-1:0] trim_sum;
	logic [AW-1:0] rd_trim;
	logic [BW-1:0] block_eff, copied_now;
	logic [LW-1:0] ramp_eff;
	logic [GW-1:0] step;
	logic [GW:0]   gain_sum;
	logic [LW:0]   div_trial;
	logic [LW:0]   tr_sum;
	logic [23:0]   tq_next;
	logic [LW:0]   tr_next;
	logic [GW-1:0] tg_next;
	logic [BW-1:0] tail_i1;
	logic signed [SB-1:0] mul_a_l, mul_a_r;
	logic signed [17:0]   mul_g;
	logic signed [MW-1:0] prod_l_d, prod_r_d;
	logic signed [MW:0]   rnd_l, rnd_r;
	logic [SB-1:0] res_l, res_r;

	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) fill_p = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
		else fill_p = {1'b0, wr_ptr_q} + DEPTH_P - {1'b0, rd_ptr_q};
		fill = fill_p[AW-1:0];
		fill_c = CW'(fill);
		prime_c = CW'(prime_q);
		target_c = CW'(target_q);
		max_c = CW'(max_q);
		block_eff = (block_q > MAX_BLK) ? MAX_BLK : block_q;
		frames_c = CW'(frames_q);
		write_ok = prod_on_q && (fill != FULL_FILL);
		trim = cons_on_q && (fill_c > max_c) && (fill_c > target_c);
		trim_n = AW'(fill_c - target_c);
		trim_sum = {1'b0, rd_ptr_q} + {1'b0, trim_n};
		rd_trim = (trim_sum >= DEPTH_P) ? AW'(trim_sum - DEPTH_P) : trim_sum[AW-1:0];
		plan_silent = !cons_on_q || (!primed_q && (!prod_on_q || fill_c < prime_c));
		copied_now = (fill_c < frames_c) ? BW'(fill) : frames_q;
		ramp_eff = (ramp_q == '0) ? LW'(1) : ramp_q;
		step = div_quo_q + GW'(div_rem_q != '0);
		gain_sum = {1'b0, gain_q} + {1'b0, step};
		div_trial = {div_rem_q[LW-1:0], (div_cnt_q == 5'd16)};
		tr_sum = tr_q + div_rem_q;
		if (tr_sum >= {1'b0, ramp_eff}) begin
			tr_next = tr_sum - {1'b0, ramp_eff};
			tq_next = tq_q + 24'(div_quo_q) + 24'd1;
		end else begin
			tr_next = tr_sum;
			tq_next = tq_q + 24'(div_quo_q);
		end
		tail_i1 = tail_cnt_q + BW'(1);
		if (LW'(tail_i1) < ramp_eff) begin
			tg_next = ajb_pkg::UNITY_GAIN - GW'(tq_next + 24'(tr_next != '0));
		end else begin
			tg_next = '0;
		end
		mul_a_l = cmd.mul_pop ? ram_rdata[SB-1:0] : held_l_q;
		mul_a_r = cmd.mul_pop ? ram_rdata[2*SB-1:SB] : held_r_q;
		mul_g = cmd.mul_pop ? {1'b0, gain_q} : {1'b0, tg_q};
		prod_l_d = mul_a_l * mul_g;
		prod_r_d = mul_a_r * mul_g;
		rnd_l = $signed({prod_l_q[MW-1], prod_l_q}) + (MW+1)'(32768);
		rnd_r = $signed({prod_r_q[MW-1], prod_r_q}) + (MW+1)'(32768);
		res_l = rnd_l[SB+15:16];
		res_r = rnd_r[SB+15:16];
	end

	assign ram_we = cmd.decide && (action_q == ajb_pkg::ACT_WRITE) && write_ok;

	always_comb begin
		st.action = action_q;
		st.zero_block = (block_q == '0);
		st.plan_silent = plan_silent;
		st.copied_nz = (copied_q != '0);
		st.div_done = (div_cnt_q == '0);
		st.pops_left = (pop_cnt_q < copied_q);
		st.is_last = (frame_idx_q == frames_q - BW'(1));
		st.out_free = !out_valid || out_ready;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= ajb_pkg::PRIME_RST;
			target_q <= ajb_pkg::TARGET_RST;
			max_q <= ajb_pkg::MAX_RST;
			ramp_q <= ajb_pkg::RAMP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				ajb_pkg::REG_PRIME: prime_q <= cfg_val;
				ajb_pkg::REG_TARGET: target_q <= cfg_val;
				ajb_pkg::REG_MAX: max_q <= cfg_val;
				ajb_pkg::REG_RAMP: ramp_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= ajb_pkg::action_t'(in_action);
			left_q <= in_left;
			right_q <= in_right;
			block_q <= in_block;
			flag_q <= in_flag;
		end
		if (cmd.mul) begin
			prod_l_q <= prod_l_d;
			prod_r_q <= prod_r_d;
		end
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			primed_q <= 1'b0;
			prod_on_q <= 1'b0;
			cons_on_q <= 1'b0;
			gain_q <= '0;
			held_l_q <= '0;
			held_r_q <= '0;
			disc_q <= '0;
			acc_q <= 1'b0;
			frames_q <= '0;
			copied_q <= '0;
			pop_cnt_q <= '0;
			frame_idx_q <= '0;
			tail_cnt_q <= '0;
			underflow_q <= 1'b0;
			fill_rep_q <= '0;
			div_cnt_q <= '0;
			div_rem_q <= '0;
			div_quo_q <= '0;
			tq_q <= '0;
			tr_q <= '0;
			tg_q <= '0;
			out_valid <= 1'b0;
			out_left <= '0;
			out_right <= '0;
			out_from_queue <= 1'b0;
			out_last <= 1'b0;
			out_accepted <= 1'b0;
			out_primed <= 1'b0;
			out_fill <= '0;
			out_disc <= '0;
		end else begin
			if (cmd.decide) begin
				acc_q <= 1'b0;
				frames_q <= block_eff;
				copied_q <= '0;
				pop_cnt_q <= '0;
				case (action_q)
					ajb_pkg::ACT_WRITE: begin
						if (write_ok) begin
							wr_ptr_q <= (wr_ptr_q == FULL_FILL) ? '0 : wr_ptr_q + AW'(1);
							acc_q <= 1'b1;
						end
					end
					ajb_pkg::ACT_READ: begin
						if (block_q != '0 && trim) begin
							rd_ptr_q <= rd_trim;
							disc_q <= disc_q + 1'b1;
							gain_q <= '0;
						end
					end
					ajb_pkg::ACT_PROD: begin
						if (prod_on_q != flag_q) begin
							prod_on_q <= flag_q;
							primed_q <= 1'b0;
							gain_q <= '0;
							held_l_q <= '0;
							held_r_q <= '0;
							if (!flag_q) begin
								rd_ptr_q <= '0;
								wr_ptr_q <= '0;
								disc_q <= disc_q + 1'b1;
							end
						end
					end
					ajb_pkg::ACT_CONS: begin
						if (cons_on_q != flag_q) begin
							cons_on_q <= flag_q;
							primed_q <= 1'b0;
							gain_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.plan) begin
				frame_idx_q <= '0;
				pop_cnt_q <= '0;
				tail_cnt_q <= '0;
				tq_q <= '0;
				tr_q <= '0;
				div_cnt_q <= 5'd16;
				div_rem_q <= '0;
				div_quo_q <= '0;
				if (plan_silent) begin
					copied_q <= '0;
					underflow_q <= 1'b0;
					fill_rep_q <= LW'(fill);
				end else begin
					if (!primed_q) gain_q <= '0;
					copied_q <= copied_now;
					underflow_q <= (copied_now < frames_q);
					primed_q <= !(copied_now < frames_q);
					if (copied_now < frames_q) disc_q <= disc_q + 1'b1;
					fill_rep_q <= LW'(fill_c - CW'(copied_now));
				end
			end
			if (cmd.div_step) begin
				if (div_trial >= {1'b0, ramp_eff}) begin
					div_rem_q <= div_trial - {1'b0, ramp_eff};
					div_quo_q <= {div_quo_q[GW-2:0], 1'b1};
				end else begin
					div_rem_q <= div_trial;
					div_quo_q <= {div_quo_q[GW-2:0], 1'b0};
				end
				if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - 5'd1;
			end
			if (cmd.pop_rd) begin
				rd_ptr_q <= (rd_ptr_q == FULL_FILL) ? '0 : rd_ptr_q + AW'(1);
				pop_cnt_q <= pop_cnt_q + BW'(1);
				if (gain_q < ajb_pkg::UNITY_GAIN) begin
					gain_q <= (gain_sum > {1'b0, ajb_pkg::UNITY_GAIN}) ?
						ajb_pkg::UNITY_GAIN : gain_sum[GW-1:0];
				end
			end
			if (cmd.tail_g) begin
				tq_q <= tq_next;
				tr_q <= tr_next;
				tg_q <= tg_next;
				tail_cnt_q <= tail_i1;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
				out_accepted <= (cmd.emit_kind == ajb_pkg::EK_ONE) && acc_q;
				out_primed <= primed_q;
				out_disc <= disc_q;
				out_fill <= (cmd.emit_kind == ajb_pkg::EK_ONE) ? LW'(fill) : fill_rep_q;
				case (cmd.emit_kind)
					ajb_pkg::EK_PROD: begin
						out_left <= res_l;
						out_right <= res_r;
						out_from_queue <= st.pops_left || (tail_cnt_q == '0);
						out_last <= st.is_last;
						frame_idx_q <= frame_idx_q + BW'(1);
						if (tail_cnt_q == '0) begin
							held_l_q <= res_l;
							held_r_q <= res_r;
						end
						if (st.is_last && underflow_q) begin
							held_l_q <= '0;
							held_r_q <= '0;
							gain_q <= '0;
						end
					end
					ajb_pkg::EK_SIL: begin
						out_left <= '0;
						out_right <= '0;
						out_from_queue <= 1'b0;
						out_last <= st.is_last;
						frame_idx_q <= frame_idx_q + BW'(1);
					end
					default: begin
						out_left <= '0;
						out_right <= '0;
						out_from_queue <= 1'b0;
						out_last <= 1'b1;
					end
				endcase
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= ajb_pkg::UNITY_GAIN)
		else $error("Envelope gain above unity.");

	a_pops_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pop_cnt_q <= copied_q)
		else $error("More frames popped than planned.");

	a_copied_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		copied_q <= frames_q)
		else $error("Planned pops exceed the block.");

	a_write_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (wr_ptr_q != $past(wr_ptr_q)))
		else $error("Write pointer did not advance on a stored frame.");

endmodule

`default_nettype wire

### test/audio_jitter_buffer_fade_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_jitter_buffer_fade_tb
// Self-checking bench for the stereo jitter buffer: a clocked driver feeds
// command words from a queue, and a clocked monitor predicts every result
// word and compares it field by field. The run covers priming, trimming,
// fades, underflow, a long output stall and several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_jitter_buffer_fade_tb;

	typedef struct {
		ajb_pkg::action_t act;
		logic [23:0] left;
		logic [23:0] right;
		logic [6:0]  frames;
		logic        flag;
	} command_t;

	typedef struct {
		logic [23:0] left;
		logic [23:0] right;
		logic        from_queue;
		logic        last;
		logic        accepted;
		logic        primed;
		logic [11:0] fill;
		logic [15:0] disc;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ajb_pkg::LEVEL_W-1:0] cfg_data = '0;

	command_t pending_cmds[$];
	frame_result_t expected_frames[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cnt = 0;
	logic hold_trig = 1'b0;
	logic hold_seen = 1'b0;
	int errors = 0;
	int n_words = 0;
	int n_reads = 0;
	int n_popped = 0;
	int n_tail = 0;

	// Predictor state
	logic [47:0] store [0:4095];
	logic [11:0] rd_ptr = '0, wr_ptr = '0;
	logic primed_st = 1'b0, prod_on = 1'b0, cons_on = 1'b0;
	longint gain_st = 0, held_l = 0, held_r = 0;
	logic [15:0] disc_st = '0;
	longint prime_lvl = 480, target_lvl = 720, max_lvl = 1440, ramp_len = 96;

	audio_jitter_buffer_fade i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint scaled(longint s, longint g);
		return (s * g + 32768) >>> 16;
	endfunction

	task automatic predict_frames(input command_t c);
		frame_result_t r, blk[$];
		longint fill, count, copied, step, rr, l, rt, g, i1;
		logic [47:0] w;
		logic silent, acc;
		count = 1;
		acc = 1'b0;
		silent = 1'b0;
		r = '{default: '0};
		blk = {};
		fill = 12'(wr_ptr - rd_ptr);
		case (c.act)
			ajb_pkg::ACT_WRITE: begin
				if (prod_on && fill < 4095) begin
					store[wr_ptr] = {c.right, c.left};
					wr_ptr = wr_ptr + 12'd1;
					acc = 1'b1;
				end
				blk.push_back(r);
			end
			ajb_pkg::ACT_READ: begin
				if (c.frames == 0) return;
				count = (c.frames > 64) ? 64 : c.frames;
				n_reads++;
				copied = 0;
				if (!cons_on) silent = 1'b1;
				else begin
					if (fill > max_lvl && fill > target_lvl) begin
						rd_ptr = rd_ptr + 12'(fill - target_lvl);
						disc_st++;
						gain_st = 0;
					end
					fill = 12'(wr_ptr - rd_ptr);
					if (!primed_st) begin
						if (!prod_on || fill < prime_lvl) silent = 1'b1;
						else begin
							primed_st = 1'b1;
							gain_st = 0;
						end
					end
				end
				if (silent) begin
					repeat (count) blk.push_back(r);
				end else begin
					rr = (ramp_len == 0) ? 1 : ramp_len;
					step = (65536 + rr - 1) / rr;
					copied = (fill < count) ? fill : count;
					for (int f = 0; f < copied; f++) begin
						w = store[rd_ptr];
						rd_ptr = rd_ptr + 12'd1;
						if (gain_st < 65536) begin
							gain_st += step;
							if (gain_st > 65536) gain_st = 65536;
						end
						l = scaled(longint'($signed(w[23:0])), gain_st);
						rt = scaled(longint'($signed(w[47:24])), gain_st);
						r.left = l[23:0];
						r.right = rt[23:0];
						r.from_queue = 1'b1;
						blk.push_back(r);
						held_l = l;
						held_r = rt;
						n_popped++;
					end
					r.from_queue = 1'b0;
					if (copied < count) begin
						disc_st++;
						primed_st = 1'b0;
						for (longint f = copied; f < count; f++) begin
							i1 = f - copied + 1;
							g = (rr > i1) ? ((rr - i1) * 65536) / rr : 0;
							l = scaled(held_l, g);
							rt = scaled(held_r, g);
							r.left = l[23:0];
							r.right = rt[23:0];
							blk.push_back(r);
							n_tail++;
						end
						held_l = 0;
						held_r = 0;
						gain_st = 0;
					end
				end
			end
			ajb_pkg::ACT_PROD: begin
				if (prod_on != c.flag) begin
					prod_on = c.flag;
					primed_st = 1'b0;
					gain_st = 0;
					held_l = 0;
					held_r = 0;
					if (!c.flag) begin
						rd_ptr = '0;
						wr_ptr = '0;
						disc_st++;
					end
				end
				blk.push_back(r);
			end
			default: begin
				if (cons_on != c.flag) begin
					cons_on = c.flag;
					primed_st = 1'b0;
					gain_st = 0;
				end
				blk.push_back(r);
			end
		endcase
		foreach (blk[k]) begin
			blk[k].last = (k == blk.size() - 1);
			blk[k].accepted = acc;
			blk[k].primed = primed_st;
			blk[k].fill = wr_ptr - rd_ptr;
			blk[k].disc = disc_st;
			expected_frames.push_back(blk[k]);
		end
	endtask

	// Driver for the command stream and the receiver's ready.
	always @(posedge clk or negedge arst_n) begin
		command_t c;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					c = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= c.act;
					s_tdata <= {c.flag, c.frames, c.right, c.left};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_cnt <= 600;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Monitor: predict on every accepted command word, then check the result word.
	always @(posedge clk) begin
		command_t c;
		frame_result_t e;
		if (arst_n && s_tvalid && s_tready) begin
			c.act = ajb_pkg::action_t'(s_tuser);
			c.left = s_tdata[23:0];
			c.right = s_tdata[47:24];
			c.frames = s_tdata[54:48];
			c.flag = s_tdata[55];
			predict_frames(c);
		end
		if (arst_n && m_tvalid && m_tready) begin
			n_words++;
			if (expected_frames.size() == 0) begin
				$error("Result word with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				e = expected_frames.pop_front();
				if (m_tdata[23:0] !== e.left) begin
					$error("out_left: expected %h, got %h", e.left, m_tdata[23:0]);
					errors++;
				end
				if (m_tdata[47:24] !== e.right) begin
					$error("out_right: expected %h, got %h", e.right, m_tdata[47:24]);
					errors++;
				end
				if (m_tuser[0] !== e.from_queue) begin
					$error("from_queue: expected %b, got %b", e.from_queue, m_tuser[0]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_frame: expected %b, got %b", e.last, m_tlast);
					errors++;
				end
				if (m_tdata[48] !== e.accepted) begin
					$error("write_accepted: expected %b, got %b", e.accepted, m_tdata[48]);
					errors++;
				end
				if (m_tdata[49] !== e.primed) begin
					$error("primed_now: expected %b, got %b", e.primed, m_tdata[49]);
					errors++;
				end
				if (m_tdata[61:50] !== e.fill) begin
					$error("fill_level: expected %0d, got %0d", e.fill, m_tdata[61:50]);
					errors++;
				end
				if (m_tdata[77:62] !== e.disc) begin
					$error("discontinuity_count: expected %0d, got %0d", e.disc,
						m_tdata[77:62]);
					errors++;
				end
			end
		end
	end

	task automatic queue_cmd(ajb_pkg::action_t a, logic [23:0] l, logic [23:0] r,
		logic [6:0] n, logic f);
		command_t c;
		c.act = a;
		c.left = l;
		c.right = r;
		c.frames = n;
		c.flag = f;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_random(int n);
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			if (p < 55)
				queue_cmd(ajb_pkg::ACT_WRITE, 24'($urandom), 24'($urandom), 7'($urandom),
					1'($urandom));
			else if (p < 88)
				queue_cmd(ajb_pkg::ACT_READ, 24'($urandom), 24'($urandom),
					7'($urandom_range(1, 8)), 1'($urandom));
			else if (p < 93)
				queue_cmd(ajb_pkg::ACT_READ, 24'($urandom), 24'($urandom),
					7'($urandom_range(0, 127)), 1'($urandom));
			else
				queue_cmd(ajb_pkg::action_t'($urandom_range(2, 3)), 24'($urandom),
					24'($urandom), 7'($urandom), $urandom_range(99) < 75);
		end
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || s_tvalid || expected_frames.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [ajb_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ajb_pkg::LEVEL_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ajb_pkg::REG_PRIME:  prime_lvl = val;
			ajb_pkg::REG_TARGET: target_lvl = val;
			ajb_pkg::REG_MAX:    max_lvl = val;
			default:             ramp_len = val;
		endcase
	endtask

	task automatic set_levels(int unsigned p, int unsigned t, int unsigned m, int unsigned r);
		write_reg(ajb_pkg::REG_PRIME, p);
		write_reg(ajb_pkg::REG_TARGET, t);
		write_reg(ajb_pkg::REG_MAX, m);
		write_reg(ajb_pkg::REG_RAMP, r);
	endtask

	task automatic run_random(int n, int s_idle, int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		queue_cmd(ajb_pkg::ACT_PROD, '0, '0, '0, 1'b1);
		queue_cmd(ajb_pkg::ACT_CONS, '0, '0, '0, 1'b1);
		queue_random(n);
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		set_levels(4, 6, 12, 3);

		// Directed words: silent reads, dropped writes, extremes, underflow, trim, flush.
		queue_cmd(ajb_pkg::ACT_CONS, '0, '0, '0, 1'b1);
		queue_cmd(ajb_pkg::ACT_CONS, '0, '0, '0, 1'b1);
		queue_cmd(ajb_pkg::ACT_READ, '0, '0, 7'd2, 1'b0);
		queue_cmd(ajb_pkg::ACT_WRITE, 24'h123456, 24'h654321, '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_PROD, '0, '0, '0, 1'b1);
		queue_cmd(ajb_pkg::ACT_WRITE, 24'h800000, 24'h7FFFFF, 7'h7F, 1'b1);
		queue_cmd(ajb_pkg::ACT_WRITE, 24'h7FFFFF, 24'h800000, '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_WRITE, 24'hFFFFFF, 24'h000000, '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_READ, '0, '0, 7'd1, 1'b0);
		queue_cmd(ajb_pkg::ACT_WRITE, 24'h000000, 24'hFFFFFF, '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_READ, '0, '0, 7'd0, 1'b0);
		queue_cmd(ajb_pkg::ACT_READ, 24'hFFFFFF, 24'hFFFFFF, 7'd127, 1'b1);
		for (int i = 0; i < 14; i++)
			queue_cmd(ajb_pkg::ACT_WRITE, 24'($urandom), 24'($urandom), '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_READ, '0, '0, 7'd64, 1'b0);
		queue_cmd(ajb_pkg::ACT_PROD, '0, '0, '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_CONS, '0, '0, '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_READ, '0, '0, 7'd3, 1'b0);
		drain();

		set_levels(0, 0, 1, 0);
		run_random(45, 0, 0);
		set_levels(10, 5, 4095, 4095);
		run_random(45, 87, 0);
		set_levels(3, 8, 30, 1);
		run_random(45, 0, 87);
		set_levels(480, 720, 1440, 96);
		queue_cmd(ajb_pkg::ACT_PROD, '0, '0, '0, 1'b0);
		run_random(20, 13, 13);
		set_levels(6, 16, 40, 5);
		run_random(40, 13, 13);

		// Long receiver stall with writes and a read queued behind it.
		set_levels(2, 10, 20, 4);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_cmd(ajb_pkg::ACT_PROD, '0, '0, '0, 1'b0);
		queue_cmd(ajb_pkg::ACT_PROD, '0, '0, '0, 1'b1);
		for (int i = 0; i < 40; i++)
			queue_cmd(ajb_pkg::ACT_WRITE, 24'($urandom), 24'($urandom), '0, 1'b0);
		hold_trig = ~hold_trig;
		queue_cmd(ajb_pkg::ACT_READ, '0, '0, 7'd16, 1'b0);
		drain();

		$display("Checked %0d result words over %0d reads: %0d frames popped, %0d fade-tail frames.",
			n_words, n_reads, n_popped, n_tail);
		if (errors == 0 && expected_frames.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
